### rtl/core/hee_pkg.sv
// ----------------------------------------------------------------------------
// hee_pkg
// Shared constants, types and entity tables of the html entity escaper.
// ----------------------------------------------------------------------------
package hee_pkg;

	// lookahead window depth (six bytes)
	localparam int DEPTH  = 6;
	localparam int FILL_W = $clog2(DEPTH + 1);

	// queue between front and back, depth a power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// character codes
	localparam logic [7:0] CH_AMP   = 8'h26; // &
	localparam logic [7:0] CH_SEMI  = 8'h3B; // ;
	localparam logic [7:0] CH_HASH  = 8'h23; // #
	localparam logic [7:0] CH_LT    = 8'h3C; // <
	localparam logic [7:0] CH_GT    = 8'h3E; // >
	localparam logic [7:0] CH_QUOT  = 8'h22; // "
	localparam logic [7:0] CH_APOS  = 8'h27; // '
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	// what the back end writes for one head byte
	typedef enum logic [2:0] {
		KIND_BYTE = 3'd0,
		KIND_LT   = 3'd1,
		KIND_GT   = 3'd2,
		KIND_AMP  = 3'd3,
		KIND_QUOT = 3'd4,
		KIND_APOS = 3'd5
	} kind_t;

	// one classified head byte
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} item_t;

	// index of the final output byte for a kind
	function automatic logic [2:0] ent_last_idx(input kind_t kind);
		logic [2:0] r;
		unique case (kind)
			KIND_BYTE: r = 3'd0;
			KIND_LT:   r = 3'd3;
			KIND_GT:   r = 3'd3;
			KIND_AMP:  r = 3'd4;
			KIND_QUOT: r = 3'd5;
			KIND_APOS: r = 3'd5;
			default:   r = 3'd0;
		endcase
		return r;
	endfunction

	// output byte at a position of the expansion
	function automatic logic [7:0] ent_char(input kind_t kind, input logic [2:0] idx,
		input logic [7:0] data);
		logic [7:0] r;
		r = CH_SEMI;
		unique case (kind)
			KIND_BYTE: r = data;
			KIND_LT: begin
				unique case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_L;
					3'd2:    r = CH_T;
					default: r = CH_SEMI;
				endcase
			end
			KIND_GT: begin
				unique case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_G;
					3'd2:    r = CH_T;
					default: r = CH_SEMI;
				endcase
			end
			KIND_AMP: begin
				unique case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_A;
					3'd2:    r = CH_M;
					3'd3:    r = CH_P;
					default: r = CH_SEMI;
				endcase
			end
			KIND_QUOT: begin
				unique case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_Q;
					3'd2:    r = CH_U;
					3'd3:    r = CH_O;
					3'd4:    r = CH_T;
					default: r = CH_SEMI;
				endcase
			end
			KIND_APOS: begin
				unique case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_A;
					3'd2:    r = CH_P;
					3'd3:    r = CH_O;
					3'd4:    r = CH_S;
					default: r = CH_SEMI;
				endcase
			end
			default: r = data;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/hee_front.sv
// ----------------------------------------------------------------------------
// hee_front
// Lookahead window: takes text bytes, classifies the oldest byte once the
// window is full or being flushed, and pushes it to the queue.
// ----------------------------------------------------------------------------
module hee_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_tvalid,
	output logic           in_tready,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	output logic           push,
	output hee_pkg::item_t push_item,
	input  logic           full
);
	import hee_pkg::*;

	logic [7:0]        win_q [DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic              flush_q;
	logic              proc;
	logic              acc;
	logic [FILL_W-1:0] wr_pos;
	logic              m_lt, m_gt, m_amp, m_quot, m_apos, m_num;

	// head goes out when the window is full, or while flushing
	assign proc = !full && ((fill_q == FILL_W'(DEPTH)) || (flush_q && fill_q != '0));
	assign in_tready = !flush_q && ((fill_q != FILL_W'(DEPTH)) || proc);
	assign acc = in_tvalid && in_tready;
	assign wr_pos = proc ? fill_q - FILL_W'(1) : fill_q;

	// entity matches from the head, limited to the bytes held
	assign m_lt   = (fill_q >= FILL_W'(4)) && win_q[1] == CH_L && win_q[2] == CH_T
		&& win_q[3] == CH_SEMI;
	assign m_gt   = (fill_q >= FILL_W'(4)) && win_q[1] == CH_G && win_q[2] == CH_T
		&& win_q[3] == CH_SEMI;
	assign m_amp  = (fill_q >= FILL_W'(5)) && win_q[1] == CH_A && win_q[2] == CH_M
		&& win_q[3] == CH_P && win_q[4] == CH_SEMI;
	assign m_quot = (fill_q >= FILL_W'(6)) && win_q[1] == CH_Q && win_q[2] == CH_U
		&& win_q[3] == CH_O && win_q[4] == CH_T && win_q[5] == CH_SEMI;
	assign m_apos = (fill_q >= FILL_W'(6)) && win_q[1] == CH_A && win_q[2] == CH_P
		&& win_q[3] == CH_O && win_q[4] == CH_S && win_q[5] == CH_SEMI;
	assign m_num  = (fill_q >= FILL_W'(2)) && win_q[1] == CH_HASH;

	// classify the head byte
	always_comb begin
		push_item.data = win_q[0];
		push_item.last = flush_q && (fill_q == FILL_W'(1));
		priority if (win_q[0] == CH_LT) begin
			push_item.kind = KIND_LT;
		end else if (win_q[0] == CH_GT) begin
			push_item.kind = KIND_GT;
		end else if (win_q[0] == CH_QUOT) begin
			push_item.kind = KIND_QUOT;
		end else if (win_q[0] == CH_APOS) begin
			push_item.kind = KIND_APOS;
		end else if (win_q[0] == CH_AMP) begin
			push_item.kind = (m_lt || m_gt || m_amp || m_quot || m_apos || m_num)
				? KIND_BYTE : KIND_AMP;
		end else begin
			push_item.kind = KIND_BYTE;
		end
	end

	assign push = proc;

	// window shift and write
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (acc && wr_pos == FILL_W'(i)) begin
				win_q[i] <= in_byte;
			end else if (proc && i < DEPTH - 1) begin
				win_q[i] <= win_q[(i + 1) % DEPTH];
			end
		end
	end

	// fill count and flush flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			flush_q <= 1'b0;
		end else begin
			fill_q <= fill_q + FILL_W'(acc) - FILL_W'(proc);
			if (acc && in_last) begin
				flush_q <= 1'b1;
			end else if (proc && fill_q == FILL_W'(1)) begin
				flush_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/hee_queue.sv
// ----------------------------------------------------------------------------
// hee_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hee_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hee_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output hee_pkg::item_t head_item
);
	import hee_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers wrap on their own, the depth being a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

### rtl/core/hee_back.sv
// ----------------------------------------------------------------------------
// hee_back
// Expands each queued item into its output bytes, one byte a cycle while
// out_tready allows, into an output register.
// ----------------------------------------------------------------------------
module hee_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  hee_pkg::item_t head_item,
	output logic           pop,
	output logic           out_tvalid,
	input  logic           out_tready,
	output logic [7:0]     out_byte,
	output logic           out_last
);
	import hee_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       load;
	logic       fin;

	assign load = head_valid && (!out_valid_q || out_tready);
	assign fin  = (idx_q == ent_last_idx(head_item.kind));
	assign pop  = load && fin;

	assign out_tvalid = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_last   = out_last_q;

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= ent_char(head_item.kind, idx_q, head_item.data);
			out_last_q <= fin && head_item.last;
		end
	end

	// expansion position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= fin ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/html_entity_escaper.sv
// ----------------------------------------------------------------------------
// html_entity_escaper
// Streaming HTML entity escaper with a six-byte lookahead window.
// ----------------------------------------------------------------------------
// channel | dir | tdata            | tlast
// s_*     | in  | [7:0] text byte  | final byte of the string
// m_*     | out | [7:0] out byte   | final escaped byte of the string
//
// One text byte is taken each cycle while the window is not flushing and,
// once the window is full, the queue has room for its head.
// Output runs at one byte a cycle unless m_tready is low; an escape of 4 to 6
// bytes holds the back end, and through the four-entry queue sets the rate.
// A final byte flushes up to 6 bytes, s_tready low, one a cycle unless q_full.
// Reset clears window fill, flush flag, queue pointers and output valid.
// A full window sends its head via the queue and the output register to m_*.
// ----------------------------------------------------------------------------
module html_entity_escaper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast
);
	import hee_pkg::*;

	logic  q_push;
	item_t q_push_item;
	logic  q_full;
	logic  q_pop;
	logic  q_valid;
	item_t q_head;

	// front: window and classification
	hee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_tvalid),
		.in_tready (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full)
	);

	// queue between the two halves
	hee_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_head)
	);

	// back: entity expansion
	hee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_item  (q_head),
		.pop        (q_pop),
		.out_tvalid (m_tvalid),
		.out_tready (m_tready),
		.out_byte   (m_tdata),
		.out_last   (m_tlast)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue overflow");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue underflow");

	// a final byte starts a flush that holds off the next item
	a_flush_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("item taken during flush");

endmodule
